// ===== src/bpa_pkg.sv =====
// Shared types and constants of the bitmap page allocator.
package bpa_pkg;

    localparam int unsigned PAGE_W      = 12;
    localparam int unsigned COUNT_W     = 13;
    localparam int unsigned STATUS_W    = 2;
    localparam int unsigned CFG_INDEX_W = 8;
    localparam int unsigned CFG_DATA_W  = 13;
    localparam int unsigned PAGE_CNT_W  = 14;

    localparam logic [COUNT_W-1:0] DEFAULT_TOTAL = 13'd4096;

    localparam logic [CFG_INDEX_W-1:0] REG_ENABLE      = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TOTAL_PAGES = 8'd1;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_DONE   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_REJECT = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_RUN = 2'd2;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SEEK,
        ST_READ,
        ST_LOAD,
        ST_SCAN,
        ST_MARK,
        ST_FREE,
        ST_RESP
    } state_t;

    typedef enum logic [1:0] {
        MODE_SCAN,
        MODE_MARK,
        MODE_FREE
    } mode_t;

endpackage

// ===== src/bpa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bpa_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 64
) (
    input  logic                                       clk,
    input  logic                                       wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                           wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                           rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== src/bitmap_page_allocator.sv =====
// Top level of the first-fit bitmap page allocator with its word-serial scan sequencer.
//
// Requests arrive as words on the s_ channel (operation, start_page, page_count) and each one
// gives one result word on the m_ channel (status, start_page_out, used_pages), unless a
// total_pages write cuts it short. The cfg channel writes enable (index 0) and total_pages
// (index 1); it is always ready. One request is worked on at a time and s_ready is low until
// its result is registered. The bitmap sits in a RAM of PAGES/WORD_BITS words; every word
// visited is read through the registered RAM port and then walked one page bit at a time,
// so the RAM read port and the single page walker set the rate. A fully used word is skipped
// without walking its bits. An allocate scans from page 0 for the first free run of
// page_count pages, then goes back to the run's first word to mark it. A free steps to the
// word of start_page and clears the pages up to start_page + page_count, capped at the
// managed page count. Rejected requests go straight to the response state.
// After reset, and after every write of total_pages, a pass over all PAGES/WORD_BITS words
// marks every page used; requests wait until it ends.
// A stalled receiver holds the result in the output register; the next request can be
// accepted and worked on, and its result waits until the previous word is taken.
module bitmap_page_allocator #(
    parameter int unsigned PAGES     = 4096,
    parameter int unsigned WORD_BITS = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_operation,
    input  logic [bpa_pkg::PAGE_W-1:0]      s_start_page,
    input  logic [bpa_pkg::COUNT_W-1:0]     s_page_count,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [bpa_pkg::STATUS_W-1:0]    m_status,
    output logic [bpa_pkg::PAGE_W-1:0]      m_start_page_out,
    output logic [bpa_pkg::COUNT_W-1:0]     m_used_pages,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bpa_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bpa_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import bpa_pkg::*;

    localparam int unsigned MAP_WORDS = (PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int unsigned AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int unsigned BW        = $clog2(WORD_BITS);
    localparam int unsigned PGW       = PAGE_CNT_W;

    localparam logic [COUNT_W-1:0] PAGES_CAP  = COUNT_W'((PAGES > 8191) ? 8191 : PAGES);
    localparam logic [COUNT_W-1:0] RESET_USED = COUNT_W'((PAGES > 4096) ? 4096 : PAGES);
    localparam logic [AW-1:0]      LAST_ADDR  = AW'(MAP_WORDS - 1);
    localparam logic [BW-1:0]      LAST_BIT   = BW'(WORD_BITS - 1);
    localparam logic [COUNT_W-1:0] WORD_STEP  = COUNT_W'(WORD_BITS);

    state_t                 state_reg, state_next;
    mode_t                  mode_reg, mode_next;
    logic                   enable_reg, enable_next;
    logic [COUNT_W-1:0]     total_reg, total_next;
    logic [COUNT_W-1:0]     used_reg, used_next;
    logic [PGW-1:0]         page_reg, page_next;
    logic [PGW-1:0]         end_reg, end_next;
    logic [PGW-1:0]         run_page_reg, run_page_next;
    logic [AW-1:0]          addr_reg, addr_next;
    logic [AW-1:0]          run_addr_reg, run_addr_next;
    logic [BW-1:0]          bit_reg, bit_next;
    logic [BW-1:0]          run_bit_reg, run_bit_next;
    logic [COUNT_W-1:0]     run_reg, run_next;
    logic [COUNT_W-1:0]     rem_reg, rem_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic [WORD_BITS-1:0]   word_reg, word_next;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic [PAGE_W-1:0]      found_reg, found_next;
    logic                   m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]    m_status_reg;
    logic [PAGE_W-1:0]      m_start_reg;
    logic [COUNT_W-1:0]     m_used_reg;

    logic                   load_out;
    logic                   wr_en_c;
    logic [WORD_BITS-1:0]   wr_data_c;
    logic [WORD_BITS-1:0]   rd_data;
    logic [WORD_BITS-1:0]   bit_mask;
    logic [COUNT_W-1:0]     limit_c;
    logic [PGW-1:0]         limit_w;
    logic [PGW-1:0]         req_end;
    logic [COUNT_W:0]       run_inc;

    bpa_ram #(
        .WIDTH(WORD_BITS),
        .DEPTH(MAP_WORDS)
    ) u_map (
        .clk     (aclk),
        .wr_en   (wr_en_c),
        .wr_addr (addr_reg),
        .wr_data (wr_data_c),
        .rd_addr (addr_reg),
        .rd_data (rd_data)
    );

    assign limit_c   = (total_reg > PAGES_CAP) ? PAGES_CAP : total_reg;
    assign limit_w   = PGW'(limit_c);
    assign req_end   = ((PGW'(s_start_page) + PGW'(s_page_count)) > limit_w) ? limit_w :
                       (PGW'(s_start_page) + PGW'(s_page_count));
    assign bit_mask  = WORD_BITS'(1) << bit_reg;
    assign run_inc   = {1'b0, run_reg} + 1'b1;
    assign wr_data_c = (state_reg == ST_CLEAR) ? '1 : word_next;

    assign s_ready          = (state_reg == ST_IDLE);
    assign cfg_ready        = 1'b1;
    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_start_page_out = m_start_reg;
    assign m_used_pages     = m_used_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            mode_reg    <= MODE_SCAN;
            enable_reg  <= 1'b0;
            total_reg   <= DEFAULT_TOTAL;
            used_reg    <= RESET_USED;
            addr_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            enable_reg  <= enable_next;
            total_reg   <= total_next;
            used_reg    <= used_next;
            addr_reg    <= addr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        page_reg     <= page_next;
        end_reg      <= end_next;
        run_page_reg <= run_page_next;
        run_addr_reg <= run_addr_next;
        bit_reg      <= bit_next;
        run_bit_reg  <= run_bit_next;
        run_reg      <= run_next;
        rem_reg      <= rem_next;
        count_reg    <= count_next;
        word_reg     <= word_next;
        status_reg   <= status_next;
        found_reg    <= found_next;
        if (load_out) begin
            m_status_reg <= status_reg;
            m_start_reg  <= found_reg;
            m_used_reg   <= used_reg;
        end
    end

    always_comb begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        enable_next   = enable_reg;
        total_next    = total_reg;
        used_next     = used_reg;
        page_next     = page_reg;
        end_next      = end_reg;
        run_page_next = run_page_reg;
        run_addr_next = run_addr_reg;
        addr_next     = addr_reg;
        bit_next      = bit_reg;
        run_bit_next  = run_bit_reg;
        run_next      = run_reg;
        rem_next      = rem_reg;
        count_next    = count_reg;
        word_next     = word_reg;
        status_next   = status_reg;
        found_next    = found_reg;
        wr_en_c       = 1'b0;
        load_out      = 1'b0;

        unique case (state_reg)
            ST_CLEAR: begin
                wr_en_c = 1'b1;
                if (addr_reg == LAST_ADDR) begin
                    addr_next  = '0;
                    state_next = ST_IDLE;
                end else begin
                    addr_next = addr_reg + AW'(1);
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    count_next  = s_page_count;
                    status_next = STATUS_DONE;
                    found_next  = '0;
                    addr_next   = '0;
                    if (!enable_reg || s_page_count == '0) begin
                        status_next = STATUS_REJECT;
                        state_next  = ST_RESP;
                    end else if (s_operation == OP_ALLOC) begin
                        mode_next  = MODE_SCAN;
                        page_next  = '0;
                        bit_next   = '0;
                        run_next   = '0;
                        state_next = ST_READ;
                    end else if (s_start_page == '0) begin
                        status_next = STATUS_REJECT;
                        state_next  = ST_RESP;
                    end else begin
                        mode_next  = MODE_FREE;
                        page_next  = PGW'(s_start_page);
                        rem_next   = COUNT_W'(s_start_page);
                        end_next   = req_end;
                        state_next = ST_SEEK;
                    end
                end
            end
            ST_SEEK: begin
                if (rem_reg >= WORD_STEP) begin
                    rem_next  = rem_reg - WORD_STEP;
                    addr_next = addr_reg + AW'(1);
                end else begin
                    bit_next   = rem_reg[BW-1:0];
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                if (mode_reg == MODE_SCAN && page_reg >= limit_w) begin
                    status_next = STATUS_NO_RUN;
                    state_next  = ST_RESP;
                end else if (mode_reg == MODE_FREE && page_reg >= end_reg) begin
                    state_next = ST_RESP;
                end else begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                word_next = rd_data;
                if (mode_reg == MODE_SCAN) begin
                    state_next = ST_SCAN;
                end else if (mode_reg == MODE_MARK) begin
                    state_next = ST_MARK;
                end else begin
                    state_next = ST_FREE;
                end
            end
            ST_SCAN: begin
                if (page_reg >= limit_w) begin
                    status_next = STATUS_NO_RUN;
                    state_next  = ST_RESP;
                end else if (bit_reg == '0 && (&word_reg)) begin
                    run_next   = '0;
                    page_next  = page_reg + PGW'(WORD_BITS);
                    addr_next  = addr_reg + AW'(1);
                    state_next = ST_READ;
                end else begin
                    if (!word_reg[bit_reg]) begin
                        run_next = run_inc[COUNT_W-1:0];
                        if (run_reg == '0) begin
                            run_page_next = page_reg;
                            run_addr_next = addr_reg;
                            run_bit_next  = bit_reg;
                        end
                    end else begin
                        run_next = '0;
                    end
                    if (!word_reg[bit_reg] && run_inc >= {1'b0, count_reg}) begin
                        mode_next  = MODE_MARK;
                        rem_next   = count_reg;
                        state_next = ST_READ;
                        if (run_reg == '0) begin
                            page_next  = page_reg;
                            found_next = page_reg[PAGE_W-1:0];
                        end else begin
                            page_next  = run_page_reg;
                            addr_next  = run_addr_reg;
                            bit_next   = run_bit_reg;
                            found_next = run_page_reg[PAGE_W-1:0];
                        end
                    end else begin
                        page_next = page_reg + PGW'(1);
                        if (bit_reg == LAST_BIT) begin
                            bit_next   = '0;
                            addr_next  = addr_reg + AW'(1);
                            state_next = ST_READ;
                        end else begin
                            bit_next = bit_reg + BW'(1);
                        end
                    end
                end
            end
            ST_MARK: begin
                word_next = word_reg | bit_mask;
                rem_next  = rem_reg - COUNT_W'(1);
                page_next = page_reg + PGW'(1);
                if (rem_reg == COUNT_W'(1)) begin
                    wr_en_c    = 1'b1;
                    used_next  = used_reg + count_reg;
                    state_next = ST_RESP;
                end else if (bit_reg == LAST_BIT) begin
                    wr_en_c    = 1'b1;
                    bit_next   = '0;
                    addr_next  = addr_reg + AW'(1);
                    state_next = ST_READ;
                end else begin
                    bit_next = bit_reg + BW'(1);
                end
            end
            ST_FREE: begin
                if (page_reg >= end_reg) begin
                    wr_en_c    = 1'b1;
                    state_next = ST_RESP;
                end else begin
                    if (word_reg[bit_reg]) begin
                        word_next = word_reg & ~bit_mask;
                        used_next = used_reg - COUNT_W'(1);
                    end
                    page_next = page_reg + PGW'(1);
                    if (bit_reg == LAST_BIT) begin
                        wr_en_c    = 1'b1;
                        bit_next   = '0;
                        addr_next  = addr_reg + AW'(1);
                        state_next = ST_READ;
                    end else begin
                        bit_next = bit_reg + BW'(1);
                    end
                end
            end
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_valid) begin
            unique case (cfg_index)
                REG_ENABLE: begin
                    enable_next = cfg_data[0];
                end
                REG_TOTAL_PAGES: begin
                    total_next = cfg_data;
                    used_next  = (cfg_data > PAGES_CAP) ? PAGES_CAP : cfg_data;
                    addr_next  = '0;
                    state_next = ST_CLEAR;
                end
                default: begin
                end
            endcase
        end

        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

endmodule

// ===== sim/bitmap_page_allocator_tb.sv =====
// Self-checking testbench for the first-fit bitmap page allocator.
module bitmap_page_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bpa_pkg::*;

    localparam int unsigned MAP_PAGES    = 4096;
    localparam int unsigned REPORT_LIMIT = 10;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [PAGE_W-1:0]   first_page;
        logic [COUNT_W-1:0]  used;
    } answer_t;

    typedef struct packed {
        logic [PAGE_W-1:0]  first;
        logic [COUNT_W-1:0] count;
    } page_run_t;

    class page_map_checker;
        bit                 enabled;
        logic [COUNT_W-1:0] total_reg;
        bit [MAP_PAGES-1:0] used_map;
        int unsigned        used_pages;
        answer_t            answers_due[$];
        int unsigned        mismatches;
        int unsigned        checked;

        function new();
            enabled    = 1'b0;
            total_reg  = DEFAULT_TOTAL;
            used_map   = '1;
            used_pages = managed();
            mismatches = 0;
            checked    = 0;
        endfunction

        function int unsigned managed();
            return (total_reg > MAP_PAGES) ? MAP_PAGES : total_reg;
        endfunction

        function void write_register(logic [CFG_INDEX_W-1:0] index,
                                     logic [CFG_DATA_W-1:0] data);
            if (index == REG_ENABLE) begin
                enabled = data[0];
            end else if (index == REG_TOTAL_PAGES) begin
                total_reg  = data;
                used_map   = '1;
                used_pages = managed();
            end
        endfunction

        function answer_t note_request(logic op, logic [PAGE_W-1:0] first,
                                       logic [COUNT_W-1:0] count);
            answer_t     ans;
            int unsigned limit;
            int unsigned run;
            int unsigned run_first;
            int unsigned stop;
            bit          hit;
            ans.status     = STATUS_DONE;
            ans.first_page = '0;
            limit          = managed();
            run            = 0;
            run_first      = 0;
            hit            = 1'b0;
            if (!enabled || count == 0) begin
                ans.status = STATUS_REJECT;
            end else if (op == OP_ALLOC) begin
                for (int unsigned p = 0; p < limit && !hit; p++) begin
                    if (!used_map[p]) begin
                        if (run == 0) run_first = p;
                        run++;
                        hit = (run >= count);
                    end else begin
                        run = 0;
                    end
                end
                if (hit) begin
                    for (int unsigned p = run_first; p < run_first + count; p++) begin
                        used_map[p] = 1'b1;
                    end
                    used_pages += count;
                    ans.first_page = run_first[PAGE_W-1:0];
                end else begin
                    ans.status = STATUS_NO_RUN;
                end
            end else if (first == 0) begin
                ans.status = STATUS_REJECT;
            end else begin
                stop = first + count;
                if (stop > limit) stop = limit;
                for (int unsigned p = first; p < stop; p++) begin
                    if (used_map[p]) begin
                        used_map[p] = 1'b0;
                        used_pages--;
                    end
                end
            end
            ans.used = used_pages[COUNT_W-1:0];
            answers_due.push_back(ans);
            return ans;
        endfunction

        function void check_result(answer_t got);
            answer_t want;
            if (answers_due.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("Unexpected result word: status %0d, start %0d, used %0d.",
                             got.status, got.first_page, got.used);
                return;
            end
            want = answers_due.pop_front();
            if (got.status !== want.status || got.first_page !== want.first_page ||
                got.used !== want.used) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display(
                        "Result word %0d: expected status %0d start %0d used %0d, got %0d %0d %0d.",
                        checked, want.status, want.first_page, want.used,
                        got.status, got.first_page, got.used);
            end
            checked++;
        endfunction

        function int unsigned outstanding();
            return answers_due.size();
        endfunction

        function bit failed();
            return mismatches != 0 || answers_due.size() != 0;
        endfunction
    endclass

    localparam int unsigned LONG_HOLD  = 300;
    localparam int unsigned END_CYCLES = 100;

    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LOW  = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_HIGH = 8'hFF;

    typedef enum int {
        TAKE_ALL,
        TAKE_RANDOM,
        TAKE_PATTERN,
        TAKE_RARELY
    } take_mode_t;

    logic                   aclk         = 1'b0;
    logic                   aresetn      = 1'b0;
    logic                   s_valid      = 1'b0;
    logic                   s_ready;
    logic                   s_operation  = OP_ALLOC;
    logic [PAGE_W-1:0]      s_start_page = '0;
    logic [COUNT_W-1:0]     s_page_count = '0;
    logic                   m_valid;
    logic                   m_ready      = 1'b0;
    logic [STATUS_W-1:0]    m_status;
    logic [PAGE_W-1:0]      m_start_page_out;
    logic [COUNT_W-1:0]     m_used_pages;
    logic                   cfg_valid    = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;

    page_map_checker sb;
    page_run_t       held_runs[$];
    int              burst_left      = 0;
    int              hold_offs_asked = 0;

    bitmap_page_allocator dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_operation      (s_operation),
        .s_start_page     (s_start_page),
        .s_page_count     (s_page_count),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_start_page_out (m_start_page_out),
        .m_used_pages     (m_used_pages),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        answer_t got;
        if (aresetn && m_valid && m_ready) begin
            got.status     = m_status;
            got.first_page = m_start_page_out;
            got.used       = m_used_pages;
            sb.check_result(got);
        end
    end

    initial begin : receiver
        take_mode_t mode;
        int         mode_left;
        int         holds_done;
        logic [7:0] pattern;
        mode       = TAKE_ALL;
        mode_left  = 0;
        holds_done = 0;
        pattern    = 8'hFF;
        forever begin
            @(negedge aclk);
            if (holds_done != hold_offs_asked) begin
                holds_done = hold_offs_asked;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
            end
            if (mode_left == 0) begin
                mode      = take_mode_t'($urandom_range(0, 3));
                pattern   = 8'($urandom_range(1, 255));
                mode_left = $urandom_range(50, 400);
            end
            mode_left--;
            case (mode)
                TAKE_ALL: begin
                    m_ready <= 1'b1;
                end
                TAKE_RANDOM: begin
                    m_ready <= 1'($urandom_range(0, 1));
                end
                TAKE_PATTERN: begin
                    m_ready <= pattern[0];
                    pattern = {pattern[0], pattern[7:1]};
                end
                default: begin
                    m_ready <= ($urandom_range(0, 3) == 0);
                end
            endcase
        end
    end

    task automatic sender_pause();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 4);
            burst_left = $urandom_range(0, 24);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    task automatic send_request(input logic op, input logic [PAGE_W-1:0] first,
                                input logic [COUNT_W-1:0] count, output answer_t predicted);
        sender_pause();
        s_valid      <= 1'b1;
        s_operation  <= op;
        s_start_page <= first;
        s_page_count <= count;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = sb.note_request(op, first, count);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.outstanding() != 0) @(negedge aclk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.write_register(index, data);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic run_phase(input logic en, input logic [COUNT_W-1:0] total,
                             input bit keep_map, input int items, input int count_cap,
                             input bit squeeze);
        answer_t            ans;
        page_run_t          run;
        int unsigned        limit;
        int unsigned        first;
        int unsigned        chunk;
        int unsigned        pick;
        int unsigned        slot;
        logic               op;
        logic [PAGE_W-1:0]  at;
        logic [COUNT_W-1:0] count;
        drain();
        if (!keep_map) begin
            write_register(REG_TOTAL_PAGES, total);
            held_runs.delete();
        end
        write_register(REG_ENABLE, CFG_DATA_W'(en));
        limit = sb.managed();
        if (!keep_map) begin
            first = 1;
            while (first < limit) begin
                chunk = $urandom_range(1, limit / 4 + 8);
                send_request(OP_FREE, first[PAGE_W-1:0], chunk[COUNT_W-1:0], ans);
                first += chunk;
            end
        end
        for (int n = 0; n < items; n++) begin
            if (squeeze && n == items / 2) begin
                hold_offs_asked++;
                burst_left = 16;
            end
            pick  = $urandom_range(0, 99);
            op    = OP_ALLOC;
            at    = PAGE_W'($urandom);
            count = COUNT_W'($urandom_range(1, count_cap));
            if (pick < 45 || (pick >= 50 && pick < 80 && held_runs.size() == 0)) begin
                op = OP_ALLOC;
            end else if (pick < 50) begin
                count = COUNT_W'($urandom_range(1, (limit > 1) ? limit : 1));
            end else if (pick < 80) begin
                slot = $urandom_range(0, held_runs.size() - 1);
                run  = held_runs[slot];
                held_runs.delete(slot);
                op    = OP_FREE;
                at    = run.first;
                count = run.count;
            end else if (pick < 92) begin
                op = OP_FREE;
                at = PAGE_W'($urandom_range(1, MAP_PAGES - 1));
            end else begin
                op = 1'($urandom_range(0, 1));
                case ($urandom_range(0, 2))
                    0: begin
                        count = '0;
                    end
                    1: begin
                        op    = OP_FREE;
                        at    = '0;
                        count = COUNT_W'($urandom_range(1, 8191));
                    end
                    default: begin
                        count = COUNT_W'($urandom_range(0, 8191));
                    end
                endcase
            end
            send_request(op, at, count, ans);
            if (op == OP_ALLOC && ans.status == STATUS_DONE)
                held_runs.push_back('{ans.first_page, count});
        end
    endtask

    initial begin : watchdog
        #200_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        answer_t ans;
        sb = new();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // The block comes out of reset disabled, with every page used.
        send_request(OP_ALLOC, 12'hFFF, 13'd1, ans);
        send_request(OP_FREE, 12'd1, 13'd5, ans);
        drain();
        write_register(REG_ENABLE, 13'h1FFF);
        send_request(OP_ALLOC, 12'd0, 13'd0, ans);
        send_request(OP_FREE, 12'd7, 13'd0, ans);
        send_request(OP_FREE, 12'd0, 13'd10, ans);
        send_request(OP_ALLOC, 12'd0, 13'd1, ans);
        send_request(OP_FREE, 12'd1, 13'h1FFF, ans);
        send_request(OP_ALLOC, 12'd0, 13'd4095, ans);
        send_request(OP_ALLOC, 12'd0, 13'd1, ans);
        send_request(OP_FREE, 12'd4095, 13'd1, ans);
        send_request(OP_FREE, 12'd4095, 13'd1, ans);
        send_request(OP_FREE, 12'd2048, 13'd4096, ans);
        send_request(OP_ALLOC, 12'd0, 13'd4096, ans);
        send_request(OP_ALLOC, 12'd0, 13'd2048, ans);
        send_request(OP_FREE, 12'd1, 13'd2047, ans);
        send_request(OP_ALLOC, 12'd0, 13'd63, ans);
        send_request(OP_ALLOC, 12'd0, 13'd64, ans);
        send_request(OP_FREE, 12'd64, 13'd64, ans);
        send_request(OP_ALLOC, 12'd0, 13'd65, ans);
        drain();
        write_register(REG_TOTAL_PAGES, 13'd0);
        send_request(OP_ALLOC, 12'd0, 13'd1, ans);
        send_request(OP_FREE, 12'd5, 13'd3, ans);
        drain();
        write_register(REG_TOTAL_PAGES, 13'h1FFF);
        send_request(OP_FREE, 12'hABC, 13'd2, ans);
        send_request(OP_ALLOC, 12'd0, 13'd2, ans);
        drain();
        write_register(REG_TOTAL_PAGES, 13'd1);
        write_register(REG_UNUSED_LOW, 13'h0AAA);
        write_register(REG_UNUSED_HIGH, 13'h1555);
        send_request(OP_FREE, 12'd1, 13'd1, ans);
        send_request(OP_ALLOC, 12'd0, 13'd1, ans);

        run_phase(1'b1, 13'd64, 1'b0, 250, 8, 1'b1);
        run_phase(1'b1, 13'd65, 1'b0, 150, 8, 1'b0);
        run_phase(1'b1, 13'd200, 1'b0, 250, 16, 1'b0);
        run_phase(1'b1, 13'd1000, 1'b0, 250, 32, 1'b1);
        run_phase(1'b1, 13'd4096, 1'b0, 350, 32, 1'b0);
        run_phase(1'b0, 13'd4096, 1'b1, 40, 32, 1'b0);
        run_phase(1'b1, 13'd4096, 1'b1, 150, 64, 1'b1);
        run_phase(1'b1, 13'($urandom_range(1, 4096)), 1'b0, 200, 16, 1'b0);
        run_phase(1'b1, 13'd1, 1'b0, 30, 4, 1'b0);
        run_phase(1'b1, 13'd5000, 1'b0, 150, 16, 1'b0);
        run_phase(1'b1, 13'd0, 1'b0, 30, 4, 1'b0);

        drain();
        repeat (END_CYCLES) @(negedge aclk);
        if (sb.failed()) begin
            $display("SCOREBOARD MISMATCH");
        end else begin
            $display("SCOREBOARD CLEAN");
        end
        $finish;
    end
endmodule

// ===== bitmap_page_allocator.f =====
src/bpa_pkg.sv
src/bpa_ram.sv
src/bitmap_page_allocator.sv
sim/bitmap_page_allocator_tb.sv
